>>> rtl/lps_pkg.sv
// shared types and constants for the led pixel serializer
package lps_pkg;

   // color channels per led and how many of them go out on the wire
   localparam int CHANNELS         = 3;
   localparam int CHAN_SENT        = (CHANNELS > 3) ? 3 : ((CHANNELS < 1) ? 1 : CHANNELS);
   localparam int BITS_PER_CHANNEL = 8;
   localparam int BITS_SENT        = CHAN_SENT * BITS_PER_CHANNEL;
   localparam int BIT_CNT_W        = $clog2(BITS_SENT);

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LATCH_GAP = 3'd4;

   // register reset values
   localparam logic [7:0]  ZERO_HIGH_RESET = 8'd20;
   localparam logic [7:0]  ZERO_LOW_RESET  = 8'd42;
   localparam logic [7:0]  ONE_HIGH_RESET  = 8'd40;
   localparam logic [7:0]  ONE_LOW_RESET   = 8'd22;
   localparam logic [15:0] LATCH_GAP_RESET = 16'd2500;

   // one scaled led waiting between front and back
   typedef struct packed {
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_type;

   // floor(p / 255) for any product of two bytes, no divider needed
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] sum;
      sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

>>> rtl/lps_front.sv
// front end: accepts led requests and scales each color by the brightness level
module lps_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_level,
   input  logic              req_frame_end,
   output logic              push,
   output lps_pkg::pixel_type push_data,
   input  logic              queue_full
);
   import lps_pkg::*;

   logic        prod_valid_ff, prod_valid_in;
   logic [15:0] green_prod_ff, green_prod_in;
   logic [15:0] red_prod_ff, red_prod_in;
   logic [15:0] blue_prod_ff, blue_prod_in;
   logic        frame_end_ff, frame_end_in;
   logic        take;

   // product stage frees up when its content moves into the queue
   assign push      = prod_valid_ff && !queue_full;
   assign req_stall = prod_valid_ff && queue_full;
   assign take      = req_valid && !req_stall;

   // multiply each color by the level
   always_comb begin
      prod_valid_in = prod_valid_ff;
      green_prod_in = green_prod_ff;
      red_prod_in   = red_prod_ff;
      blue_prod_in  = blue_prod_ff;
      frame_end_in  = frame_end_ff;
      if (push) begin
         prod_valid_in = 1'b0;
      end
      if (take) begin
         prod_valid_in = 1'b1;
         green_prod_in = 16'(req_green) * 16'(req_level);
         red_prod_in   = 16'(req_red) * 16'(req_level);
         blue_prod_in  = 16'(req_blue) * 16'(req_level);
         frame_end_in  = req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
      green_prod_ff <= green_prod_in;
      red_prod_ff   <= red_prod_in;
      blue_prod_ff  <= blue_prod_in;
      frame_end_ff  <= frame_end_in;
   end

   // divide by full scale on the way into the queue
   always_comb begin
      push_data.green     = div255(green_prod_ff);
      push_data.red       = div255(red_prod_ff);
      push_data.blue      = div255(blue_prod_ff);
      push_data.frame_end = frame_end_ff;
   end

endmodule

>>> rtl/lps_queue.sv
// two-entry queue between the scaling front end and the bit serializer
module lps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lps_pkg::pixel_type push_data,
   output logic               full,
   input  logic               pop,
   output lps_pkg::pixel_type pop_data,
   output logic               not_empty
);
   import lps_pkg::*;

   pixel_type   mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/lps_back.sv
// back end: timing registers and the bit serializer with its output register
module lps_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [lps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            queue_not_empty,
   input  lps_pkg::pixel_type              queue_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_bit_value,
   output logic [7:0]                      rsp_high_ticks,
   output logic [7:0]                      rsp_low_ticks,
   output logic [15:0]                     rsp_gap_ticks,
   output logic                            rsp_last
);
   import lps_pkg::*;

   logic [7:0]  zero_high_ff, zero_high_in;
   logic [7:0]  zero_low_ff, zero_low_in;
   logic [7:0]  one_high_ff, one_high_in;
   logic [7:0]  one_low_ff, one_low_in;
   logic [15:0] latch_gap_ff, latch_gap_in;

   logic                 sh_valid_ff, sh_valid_in;
   logic [23:0]          sh_data_ff, sh_data_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 sh_frame_end_ff, sh_frame_end_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_bit_ff, out_bit_in;
   logic [7:0]  out_high_ff, out_high_in;
   logic [7:0]  out_low_ff, out_low_in;
   logic [15:0] out_gap_ff, out_gap_in;
   logic        out_last_ff, out_last_in;

   logic out_free;
   logic emit;
   logic is_last;
   logic cur_bit;

   // timing register writes
   always_comb begin
      zero_high_in = zero_high_ff;
      zero_low_in  = zero_low_ff;
      one_high_in  = one_high_ff;
      one_low_in   = one_low_ff;
      latch_gap_in = latch_gap_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ZERO_HIGH: zero_high_in = csr_data[7:0];
            REG_ZERO_LOW:  zero_low_in  = csr_data[7:0];
            REG_ONE_HIGH:  one_high_in  = csr_data[7:0];
            REG_ONE_LOW:   one_low_in   = csr_data[7:0];
            REG_LATCH_GAP: latch_gap_in = csr_data;
            default: ;
         endcase
      end
   end

   // serializer control
   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = sh_valid_ff && out_free;
   assign is_last  = (cnt_ff == BIT_CNT_W'(BITS_SENT - 1));
   assign cur_bit  = sh_data_ff[23];
   assign pop      = queue_not_empty && (!sh_valid_ff || (emit && is_last));

   // shift register and bit count, reloaded from the queue after the final bit
   always_comb begin
      sh_valid_in     = sh_valid_ff;
      sh_data_in      = sh_data_ff;
      cnt_in          = cnt_ff;
      sh_frame_end_in = sh_frame_end_ff;
      if (emit) begin
         sh_data_in = {sh_data_ff[22:0], 1'b0};
         cnt_in     = cnt_ff + BIT_CNT_W'(1);
         if (is_last) begin
            sh_valid_in = 1'b0;
         end
      end
      if (pop) begin
         sh_valid_in     = 1'b1;
         sh_data_in      = {queue_data.green, queue_data.red, queue_data.blue};
         cnt_in          = '0;
         sh_frame_end_in = queue_data.frame_end;
      end
   end

   // output register for one bit result
   always_comb begin
      out_valid_in = out_valid_ff;
      out_bit_in   = out_bit_ff;
      out_high_in  = out_high_ff;
      out_low_in   = out_low_ff;
      out_gap_in   = out_gap_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = emit;
      end
      if (emit) begin
         out_bit_in  = cur_bit;
         out_high_in = cur_bit ? one_high_ff : zero_high_ff;
         out_low_in  = cur_bit ? one_low_ff : zero_low_ff;
         out_gap_in  = (is_last && sh_frame_end_ff) ? latch_gap_ff : 16'd0;
         out_last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZERO_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
         one_high_ff  <= ONE_HIGH_RESET;
         one_low_ff   <= ONE_LOW_RESET;
         latch_gap_ff <= LATCH_GAP_RESET;
         sh_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         zero_high_ff <= zero_high_in;
         zero_low_ff  <= zero_low_in;
         one_high_ff  <= one_high_in;
         one_low_ff   <= one_low_in;
         latch_gap_ff <= latch_gap_in;
         sh_valid_ff  <= sh_valid_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      sh_data_ff      <= sh_data_in;
      sh_frame_end_ff <= sh_frame_end_in;
      out_bit_ff      <= out_bit_in;
      out_high_ff     <= out_high_in;
      out_low_ff      <= out_low_in;
      out_gap_ff      <= out_gap_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bit_value  = out_bit_ff;
   assign rsp_high_ticks = out_high_ff;
   assign rsp_low_ticks  = out_low_ff;
   assign rsp_gap_ticks  = out_gap_ff;
   assign rsp_last       = out_last_ff;

endmodule

>>> rtl/led_pixel_serializer.sv
// top level of the led pixel serializer
//
// Takes one led request (green, red, blue, brightness level, frame end) and
// returns 24 bit responses, green then red then blue, msb first, each scaled
// to floor(color * level / 255). Every response gives the high and low pulse
// lengths for its bit from the timing registers; the final bit of an led is
// marked last and, if the request ended a frame, carries the latch gap. The
// bit serializer emits one response per cycle while the receiver does not
// stall. A request passes four registers (product register, queue, shift
// register, output register) before its first response is valid.
// A two-entry queue lets new requests be taken while the serializer is busy.
// Timing registers reset to 20/42/40/22 ticks and a 2500-tick latch gap and
// are to be written by the user only while the block is idle; the block
// itself does not enforce this.
module led_pixel_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_blue,
   input  logic [7:0]                      req_level,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_bit_value,
   output logic [7:0]                      rsp_high_ticks,
   output logic [7:0]                      rsp_low_ticks,
   output logic [15:0]                     rsp_gap_ticks,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [lps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lps_pkg::*;

   logic      push;
   pixel_type push_data;
   logic      queue_full;
   logic      pop;
   pixel_type pop_data;
   logic      queue_not_empty;

   // scaling front end
   lps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_green     (req_green),
      .req_red       (req_red),
      .req_blue      (req_blue),
      .req_level     (req_level),
      .req_frame_end (req_frame_end),
      .push          (push),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   // decoupling queue
   lps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (queue_not_empty)
   );

   // bit serializer
   lps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_high_ticks  (rsp_high_ticks),
      .rsp_low_ticks   (rsp_low_ticks),
      .rsp_gap_ticks   (rsp_gap_ticks),
      .rsp_last        (rsp_last)
   );

endmodule

>>> verif/testbench.sv
// testbench for the led pixel serializer: directed and random leds, scoreboard of bit responses
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int SENT_CHANNELS = (CHANNELS > 3) ? 3 : ((CHANNELS < 1) ? 1 : CHANNELS);
   localparam int SENT_BITS     = SENT_CHANNELS * 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_MAX    = 10;
   localparam int RANDOM_LEDS   = 52;

   // one led request
   typedef struct {
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic [7:0] level;
      logic       frame_end;
   } led_req_type;

   // one bit response
   typedef struct {
      logic        bit_value;
      logic [7:0]  high_ticks;
      logic [7:0]  low_ticks;
      logic [15:0] gap_ticks;
      logic        last;
   } bit_rsp_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_green = '0;
   logic [7:0]             req_red = '0;
   logic [7:0]             req_blue = '0;
   logic [7:0]             req_level = '0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_bit_value;
   logic [7:0]             rsp_high_ticks;
   logic [7:0]             rsp_low_ticks;
   logic [15:0]            rsp_gap_ticks;
   logic                   rsp_last;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // mirror of the timing registers
   logic [7:0]  cfg_zero_high = ZERO_HIGH_RESET;
   logic [7:0]  cfg_zero_low  = ZERO_LOW_RESET;
   logic [7:0]  cfg_one_high  = ONE_HIGH_RESET;
   logic [7:0]  cfg_one_low   = ONE_LOW_RESET;
   logic [15:0] cfg_latch_gap = LATCH_GAP_RESET;

   led_req_type led_queue[$];
   led_req_type led_on_wire;
   bit_rsp_type expected_bits[$];
   bit_rsp_type want;

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   bit  drain_mode = 1'b0;
   int  error_count = 0;
   int  cycle_count = 0;

   led_pixel_serializer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_green     (req_green),
      .req_red       (req_red),
      .req_blue      (req_blue),
      .req_level     (req_level),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bit_value (rsp_bit_value),
      .rsp_high_ticks(rsp_high_ticks),
      .rsp_low_ticks (rsp_low_ticks),
      .rsp_gap_ticks (rsp_gap_ticks),
      .rsp_last      (rsp_last),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // floor(color * level / 255)
   function automatic logic [7:0] scale_color(input logic [7:0] color, input logic [7:0] level);
      int unsigned product;
      product = int'(color) * int'(level);
      return 8'(product / 255);
   endfunction

   // queue up the bit responses one led should produce
   function automatic void predict_led(input led_req_type led);
      logic [7:0]  scaled [3];
      bit_rsp_type r;
      logic        one;
      int          k;
      scaled[0] = scale_color(led.green, led.level);
      scaled[1] = scale_color(led.red, led.level);
      scaled[2] = scale_color(led.blue, led.level);
      k = 0;
      for (int c = 0; c < SENT_CHANNELS; c++) begin
         for (int b = 7; b >= 0; b--) begin
            one          = scaled[c][b];
            r.bit_value  = one;
            r.high_ticks = one ? cfg_one_high : cfg_zero_high;
            r.low_ticks  = one ? cfg_one_low : cfg_zero_low;
            r.last       = (k == SENT_BITS - 1);
            r.gap_ticks  = (r.last && led.frame_end) ? cfg_latch_gap : 16'd0;
            expected_bits.push_back(r);
            k++;
         end
      end
   endfunction

   // register write, mirror keeps only the register's width
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      unique case (idx)
         REG_ZERO_HIGH: cfg_zero_high = data[7:0];
         REG_ZERO_LOW:  cfg_zero_low  = data[7:0];
         REG_ONE_HIGH:  cfg_one_high  = data[7:0];
         REG_ONE_LOW:   cfg_one_low   = data[7:0];
         REG_LATCH_GAP: cfg_latch_gap = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_timing(input logic [15:0] zh, input logic [15:0] zl,
                               input logic [15:0] oh, input logic [15:0] ol,
                               input logic [15:0] gap);
      write_reg(REG_ZERO_HIGH, zh);
      write_reg(REG_ZERO_LOW, zl);
      write_reg(REG_ONE_HIGH, oh);
      write_reg(REG_ONE_LOW, ol);
      write_reg(REG_LATCH_GAP, gap);
   endtask

   function automatic void push_led(input logic [7:0] g, input logic [7:0] r,
                                    input logic [7:0] b, input logic [7:0] level,
                                    input logic fe);
      led_req_type led;
      led.green     = g;
      led.red       = r;
      led.blue      = b;
      led.level     = level;
      led.frame_end = fe;
      led_queue.push_back(led);
   endfunction

   // random strips, mostly whole frames, some leds with a random frame mark
   function automatic void push_random_frames(input int count);
      int          n;
      int          len;
      int          pick;
      logic [7:0]  level;
      logic        fe;
      n = 0;
      while (n < count) begin
         len = $urandom_range(1, 8);
         if (len > count - n) len = count - n;
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 15);
            if (pick < 2) level = 8'd255;
            else if (pick == 2) level = 8'd0;
            else level = 8'($urandom);
            if ($urandom_range(0, 9) == 0) fe = 1'($urandom);
            else fe = (i == len - 1);
            push_led(8'($urandom), 8'($urandom), 8'($urandom), level, fe);
         end
         n += len;
      end
   endfunction

   // start a batch of leds and wait until every response is back
   task automatic run_batch(input int send_pct, input int stall_pct, input bit drain);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      drain_mode         = drain;
      do @(negedge clock);
      while (led_queue.size() != 0 || req_valid || expected_bits.size() != 0);
      drain_mode = 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_led(led_on_wire);
         if (!req_valid || !req_stall) begin
            if (led_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
                !(drain_mode && expected_bits.size() != 0)) begin
               led_on_wire = led_queue.pop_front();
               req_valid     <= 1'b1;
               req_green     <= led_on_wire.green;
               req_red       <= led_on_wire.red;
               req_blue      <= led_on_wire.blue;
               req_level     <= led_on_wire.level;
               req_frame_end <= led_on_wire.frame_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bits.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("unexpected response: bit %0d high %0d low %0d gap %0d last %0d",
                           rsp_bit_value, rsp_high_ticks, rsp_low_ticks, rsp_gap_ticks,
                           rsp_last);
            end else begin
               want = expected_bits.pop_front();
               if (rsp_bit_value !== want.bit_value || rsp_high_ticks !== want.high_ticks ||
                   rsp_low_ticks !== want.low_ticks || rsp_gap_ticks !== want.gap_ticks ||
                   rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= REPORT_MAX) begin
                     $write("mismatch: expected bit %0d high %0d low %0d gap %0d last %0d, ",
                            want.bit_value, want.high_ticks, want.low_ticks,
                            want.gap_ticks, want.last);
                     $display("got bit %0d high %0d low %0d gap %0d last %0d",
                              rsp_bit_value, rsp_high_ticks, rsp_low_ticks,
                              rsp_gap_ticks, rsp_last);
                  end
               end
            end
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed leds on reset timing, each one drained before the next
      @(negedge clock);
      push_led(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      push_led(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      push_led(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      push_led(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
      push_led(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
      push_led(8'h80, 8'h80, 8'h80, 8'd255, 1'b0);
      push_led(8'd255, 8'd255, 8'd255, 8'd1, 1'b0);
      push_led(8'd255, 8'd254, 8'd1, 8'd254, 1'b0);
      push_led(8'hAA, 8'h55, 8'h0F, 8'd255, 1'b1);
      push_led(8'd1, 8'd2, 8'd3, 8'd255, 1'b0);
      push_led(8'h55, 8'hAA, 8'hF0, 8'd128, 1'b1);
      push_led(8'd200, 8'd100, 8'd50, 8'd127, 1'b0);
      run_batch(0, 0, 1'b1);

      // widest timing, no idling
      write_timing(16'd255, 16'd255, 16'd255, 16'd255, 16'hFFFF);
      @(negedge clock);
      push_random_frames(RANDOM_LEDS);
      run_batch(0, 0, 1'b0);

      // narrowest nonzero timing, sender mostly idle
      write_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      @(negedge clock);
      push_random_frames(RANDOM_LEDS);
      run_batch(88, 0, 1'b0);

      // zero values and oversized writes, receiver mostly stalled
      write_timing(16'd0, 16'h1234, 16'hFFFF, 16'd0, 16'd0);
      @(negedge clock);
      push_random_frames(RANDOM_LEDS);
      run_batch(0, 88, 1'b0);

      // random timing, then writes to unused indexes that must not land
      write_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      for (int i = 1; i <= 3; i++) write_reg(REG_LATCH_GAP + 3'(i), 16'($urandom));
      @(negedge clock);
      push_random_frames(RANDOM_LEDS);
      run_batch(23, 23, 1'b0);

      // fresh random timing at full rate
      write_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      @(negedge clock);
      push_random_frames(RANDOM_LEDS);
      run_batch(0, 0, 1'b0);

      // let any stray response show up
      repeat (30) @(negedge clock);
      error_count += expected_bits.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/led_pixel_serializer.sv
verif/testbench.sv
